// ===== rtl/hsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsg_pkg: shared types and constants of the heat stencil grid engine
// Command codes, payload beats, register indexes, fixed-point constants.
// ----------------------------------------------------------------------------
package hsg_pkg;

   localparam int MAX_COLS_DEF  = 64;
   localparam int MAX_ROWS_DEF  = 64;
   localparam int TEMP_BITS_DEF = 20;
   localparam int FRAC_BITS     = 10;
   localparam int RATE_BITS     = 16;
   localparam int SUM_BITS      = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [1:0] {
      CMD_INIT  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_STEP  = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_RATE   = 2'd2;

   typedef struct packed {
      cmd_type            cmd;
      logic [5:0]         col;
      logic [5:0]         row;
      logic signed [19:0] cell_value;
   } req_type;

   typedef struct packed {
      logic signed [19:0] read_value;
      logic signed [31:0] grid_sum;
      logic               coord_error;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/heat_stencil_grid_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heat_stencil_grid_engine: 5-point Jacobi heat diffusion on a fixed-point grid
// Write or bad coordinate: S_RW, S_DONE, then the registered strobe; read adds
// S_RD. Init: fill of the full MAX_COLS*MAX_ROWS array, then a sum of the cells
// in use. Step: each interior cell reads center and four neighbors on the single
// read port, passes two ALU stages and is written back; an edge or unused cell of
// the full array copies its center. Then a copy-back of one cell a cycle and
// the sum sweep. One beat at a time; busy while working. The receiver cannot
// stall: rsp_valid is a strobe. Reset: runs the init fill sweep before first start.
// ----------------------------------------------------------------------------
module heat_stencil_grid_engine import hsg_pkg::*; #(
   parameter int MAX_COLS  = MAX_COLS_DEF,
   parameter int MAX_ROWS  = MAX_ROWS_DEF,
   parameter int TEMP_BITS = TEMP_BITS_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  wire                      csr_write,
   input  wire [CSR_IDX_BITS-1:0]   csr_index,
   input  wire [CSR_DATA_BITS-1:0]  csr_data
);
   localparam int CB = $clog2(MAX_COLS);
   localparam int RB = $clog2(MAX_ROWS);
   localparam int AB = CB + RB;
   localparam int DB = 11; // holds up to 2047
   localparam logic signed [TEMP_BITS-1:0] AMBIENT = TEMP_BITS'(20 <<< FRAC_BITS);
   localparam logic signed [TEMP_BITS-1:0] HOT     = TEMP_BITS'(100 <<< FRAC_BITS);
   // constants saturate when TEMP_BITS is too narrow to hold them
   localparam logic signed [63:0] TMAX64 = (64'sd1 <<< (TEMP_BITS-1)) - 1;
   localparam logic signed [TEMP_BITS-1:0] AMB_S =
      (64'sd20 <<< FRAC_BITS) > TMAX64 ? TEMP_BITS'(TMAX64) : AMBIENT;
   localparam logic signed [TEMP_BITS-1:0] HOT_S =
      (64'sd100 <<< FRAC_BITS) > TMAX64 ? TEMP_BITS'(TMAX64) : HOT;
   localparam logic signed [32:0] TMAX_W = 33'(TMAX64);
   localparam logic signed [32:0] TMIN_W = -TMAX_W - 33'sd1;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_FILL  = 10'b0000000010,
      S_SUM   = 10'b0000000100,
      S_RW    = 10'b0000001000,
      S_RD    = 10'b0000010000,
      S_GATH  = 10'b0000100000,
      S_ALU   = 10'b0001000000,
      S_WB    = 10'b0010000000,
      S_COPY  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [6:0]            wid_ff, hgt_ff;
   logic [RATE_BITS-1:0]  rate_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff <= 7'd64; hgt_ff <= 7'd64; rate_ff <= 16'd6554;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WIDTH:  wid_ff  <= csr_data[6:0];
            REG_HEIGHT: hgt_ff  <= csr_data[6:0];
            REG_RATE:   rate_ff <= csr_data[RATE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // size in use, clamped to 3..MAX
   logic [DB-1:0] w_use, h_use;
   always_comb begin
      w_use = DB'(wid_ff);
      if (w_use < DB'(3)) w_use = DB'(3);
      if (w_use > DB'(MAX_COLS)) w_use = DB'(MAX_COLS);
      h_use = DB'(hgt_ff);
      if (h_use < DB'(3)) h_use = DB'(3);
      if (h_use > DB'(MAX_ROWS)) h_use = DB'(MAX_ROWS);
   end

   // grid memories: one write and one registered read port each
   logic signed [TEMP_BITS-1:0] cur_mem [2**AB];
   logic signed [TEMP_BITS-1:0] nxt_mem [2**AB];
   logic                        cur_we, nxt_we;
   logic [AB-1:0]               cur_wa, cur_ra, nxt_wa, nxt_ra;
   logic signed [TEMP_BITS-1:0] cur_wd, nxt_wd, cur_q_ff, nxt_q_ff;
   always_ff @(posedge clock) begin
      if (cur_we) cur_mem[cur_wa] <= cur_wd;
      cur_q_ff <= cur_mem[cur_ra];
      if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
      nxt_q_ff <= nxt_mem[nxt_ra];
   end

   // sequencer registers
   logic [DB-1:0]  x_ff, x_in, y_ff, y_in;    // cell being visited
   logic [2:0]     ph_ff, ph_in;              // read phase within a cell
   logic signed [TEMP_BITS-1:0] nb_ff [5];    // center, N, S, E, W
   logic [SUM_BITS-1:0] acc_ff, acc_in;
   logic           pend_ff, pend_in;          // copy or sum read pending
   logic [AB-1:0]  padr_ff, padr_in;
   logic           last_ff, last_in;
   req_type        req_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           rv_ff, rv_in;
   logic           sum_ff, sum_in;            // a response should follow sum sweep
   logic signed [TEMP_BITS-1:0] alu_res;

   // written value saturated to the cell width
   logic signed [32:0]          cv_w;
   logic signed [TEMP_BITS-1:0] wr_val;
   always_comb begin
      cv_w = 33'(req_ff.cell_value);
      if (cv_w > TMAX_W)      wr_val = TEMP_BITS'(TMAX_W);
      else if (cv_w < TMIN_W) wr_val = TEMP_BITS'(TMIN_W);
      else                    wr_val = TEMP_BITS'(cv_w);
   end

   hsg_alu #(.TEMP_BITS(TEMP_BITS)) u_alu (
      .clock(clock), .center(nb_ff[0]), .north(nb_ff[1]), .south(nb_ff[2]),
      .east(nb_ff[3]), .west(nb_ff[4]), .rate(rate_ff), .result(alu_res));

   function automatic logic [AB-1:0] adr(input logic [DB-1:0] x, input logic [DB-1:0] y);
      adr = {y[RB-1:0], x[CB-1:0]};
   endfunction

   // hot block test for fill
   logic [DB-1:0] cx, cy;
   logic          hot_cell;
   always_comb begin
      cx = w_use >> 1;
      cy = h_use >> 1;
      hot_cell = (x_ff + DB'(3) >= cx) && (x_ff <= cx + DB'(3)) && (x_ff < w_use) &&
                 (y_ff + DB'(3) >= cy) && (y_ff <= cy + DB'(3)) && (y_ff < h_use);
   end

   logic coord_ok;
   assign coord_ok = (DB'(req_ff.col) < w_use) && (DB'(req_ff.row) < h_use);

   logic x_last_full, y_last_full, x_last_use, y_last_use, interior;
   assign x_last_full = (x_ff == DB'(MAX_COLS-1));
   assign y_last_full = (y_ff == DB'(MAX_ROWS-1));
   assign x_last_use  = (x_ff == w_use - DB'(1));
   assign y_last_use  = (y_ff == h_use - DB'(1));
   assign interior    = (x_ff != '0) && (y_ff != '0) && (x_ff + DB'(1) < w_use)
                     && (y_ff + DB'(1) < h_use);

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; ph_in = ph_ff; acc_in = acc_ff;
      pend_in = 1'b0; padr_in = padr_ff; last_in = 1'b0;
      rsp_in = rsp_ff; rv_in = 1'b0; sum_in = sum_ff;
      cur_we = 1'b0; cur_wa = adr(x_ff, y_ff); cur_wd = AMB_S; cur_ra = adr(x_ff, y_ff);
      nxt_we = 1'b0; nxt_wa = adr(x_ff, y_ff); nxt_wd = alu_res; nxt_ra = adr(x_ff, y_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_in = '0; y_in = '0; ph_in = '0; acc_in = '0;
               rsp_in = '0;
               unique case (req_data.cmd)
                  CMD_INIT:  begin state_in = S_FILL; sum_in = 1'b1; end
                  CMD_STEP:  state_in = S_GATH;
                  default:   state_in = S_RW;
               endcase
            end
         end
         S_FILL: begin
            cur_we = 1'b1;
            cur_wd = hot_cell ? HOT_S : AMB_S;
            x_in = x_ff + DB'(1);
            if (x_last_full) begin
               x_in = '0; y_in = y_ff + DB'(1);
               if (y_last_full) begin
                  y_in = '0;
                  state_in = sum_ff ? S_SUM : S_IDLE;
               end
            end
         end
         S_SUM: begin
            // read issue at (x,y); data lands next cycle
            if (pend_ff) acc_in = acc_ff + SUM_BITS'($unsigned(SUM_BITS'(cur_q_ff)));
            if (!last_ff) begin
               pend_in = 1'b1;
               x_in = x_ff + DB'(1);
               if (x_last_use) begin
                  x_in = '0; y_in = y_ff + DB'(1);
                  if (y_last_use) last_in = 1'b1;
               end
            end else begin
               last_in = 1'b1;
               if (!pend_ff) state_in = S_DONE;
            end
            if (last_ff) pend_in = 1'b0;
         end
         S_RW: begin
            cur_ra = adr(DB'(req_ff.col), DB'(req_ff.row));
            cur_wa = cur_ra;
            cur_wd = wr_val;
            if (!coord_ok) begin
               rsp_in.coord_error = 1'b1;
               state_in = S_DONE;
            end else if (req_ff.cmd == CMD_WRITE) begin
               cur_we = 1'b1;
               state_in = S_DONE;
            end else state_in = S_RD;
         end
         S_RD: begin
            rsp_in.read_value = 20'(cur_q_ff);
            state_in = S_DONE;
         end
         S_GATH: begin
            // phases 0..4 issue center,N,S,E,W; data captured in the following phase
            ph_in = ph_ff + 3'd1;
            unique case (ph_ff)
               3'd0: cur_ra = adr(x_ff, y_ff);
               3'd1: cur_ra = adr(x_ff, y_ff - DB'(1));
               3'd2: cur_ra = adr(x_ff, y_ff + DB'(1));
               3'd3: cur_ra = adr(x_ff + DB'(1), y_ff);
               3'd4: cur_ra = adr(x_ff - DB'(1), y_ff);
               default: ;
            endcase
            if (!interior && ph_ff == 3'd1) begin
               ph_in = '0; state_in = S_WB;
            end else if (ph_ff == 3'd5) begin
               ph_in = '0; state_in = S_ALU;
            end
         end
         S_ALU: state_in = S_WB;
         S_WB: begin
            nxt_we = 1'b1;
            nxt_wd = interior ? alu_res : nb_ff[0];
            x_in = x_ff + DB'(1);
            state_in = S_GATH;
            if (x_last_full) begin
               x_in = '0; y_in = y_ff + DB'(1);
               if (y_last_full) begin
                  y_in = '0; state_in = S_COPY;
               end
            end
         end
         S_COPY: begin
            if (pend_ff) begin
               cur_we = 1'b1; cur_wa = padr_ff; cur_wd = nxt_q_ff;
            end
            if (!last_ff) begin
               pend_in = 1'b1; padr_in = adr(x_ff, y_ff);
               x_in = x_ff + DB'(1);
               if (x_last_full) begin
                  x_in = '0; y_in = y_ff + DB'(1);
                  if (y_last_full) begin
                     y_in = '0; last_in = 1'b1;
                  end
               end
            end else if (pend_ff) begin
               last_in = 1'b1;
            end else begin
               state_in = S_SUM;
            end
         end
         S_DONE: begin
            if (sum_ff) rsp_in.grid_sum = acc_ff;
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FILL;
         x_ff <= '0; y_ff <= '0; ph_ff <= '0;
         pend_ff <= 1'b0; last_ff <= 1'b0; rv_ff <= 1'b0; sum_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         x_ff <= x_in; y_ff <= y_in; ph_ff <= ph_in;
         pend_ff <= pend_in; last_ff <= last_in; rv_ff <= rv_in;
         sum_ff <= (state_ff == S_IDLE && start) ?
                   (req_data.cmd == CMD_INIT || req_data.cmd == CMD_STEP) : sum_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      padr_ff <= padr_in;
      rsp_ff <= rsp_in;
      if (state_ff == S_IDLE && start) req_ff <= req_data;
      if (state_ff == S_GATH && ph_ff != 3'd0) nb_ff[ph_ff - 3'd1] <= cur_q_ff;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// ===== rtl/hsg_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsg_alu: shared stencil arithmetic unit
// Two-stage: laplacian*rate registered, then round, add center, saturate.
// ----------------------------------------------------------------------------
module hsg_alu import hsg_pkg::*; #(
   parameter int TEMP_BITS = TEMP_BITS_DEF
) (
   input  wire                         clock,
   input  wire signed [TEMP_BITS-1:0]  center,
   input  wire signed [TEMP_BITS-1:0]  north,
   input  wire signed [TEMP_BITS-1:0]  south,
   input  wire signed [TEMP_BITS-1:0]  east,
   input  wire signed [TEMP_BITS-1:0]  west,
   input  wire        [RATE_BITS-1:0]  rate,
   output logic signed [TEMP_BITS-1:0] result
);
   localparam int LAP_BITS  = TEMP_BITS + 3;
   localparam int PROD_BITS = LAP_BITS + RATE_BITS + 1;
   localparam int D_BITS    = PROD_BITS - RATE_BITS;
   localparam logic signed [D_BITS:0] T_MAX =
      (D_BITS+1)'((64'sd1 <<< (TEMP_BITS-1)) - 1);
   localparam logic signed [D_BITS:0] T_MIN = -T_MAX - 1;

   logic signed [LAP_BITS-1:0]  lap;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [TEMP_BITS-1:0] ctr_ff;
   logic signed [PROD_BITS-1:0] rnd;
   logic signed [D_BITS:0]      tot;

   always_comb begin
      lap = LAP_BITS'(north) + LAP_BITS'(south) + LAP_BITS'(east) + LAP_BITS'(west)
          - (LAP_BITS'(center) <<< 2);
      prod_in = PROD_BITS'(lap) * $signed({1'b0, rate});
      rnd = prod_ff + PROD_BITS'(1 <<< (RATE_BITS-1));
      tot = (D_BITS+1)'(rnd >>> RATE_BITS) + (D_BITS+1)'(ctr_ff);
      if (tot > T_MAX)      result = TEMP_BITS'(T_MAX);
      else if (tot < T_MIN) result = TEMP_BITS'(T_MIN);
      else                  result = TEMP_BITS'(tot);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ctr_ff  <= center;
   end
endmodule
`default_nettype wire

// ===== rtl/hsg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsg_checker: port-level checks of the heat stencil grid engine
// Watches start/busy/response behavior from the top-level ports.
// ----------------------------------------------------------------------------
module hsg_checker import hsg_pkg::*; (
   input wire     clock,
   input wire     reset,
   input wire     start,
   input wire     busy,
   input wire     rsp_valid,
   input rsp_type rsp_data
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_rsp_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response held two cycles");
   a_err_nosum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.coord_error) |-> (rsp_data.grid_sum == '0 &&
      rsp_data.read_value == '0)) else $error("error beat carries data");
endmodule

bind heat_stencil_grid_engine hsg_checker u_hsg_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data));
`default_nettype wire
